FILE: src/folc_pkg.sv
// Shared types and constants for the fixed-capacity ordered list core.
// No dependencies; imported by the cell, the top level and the checker.
package folc_pkg;

    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int FIDX_W  = 4;
    localparam int CNT_O_W = 5;
    localparam int LIM_W   = 5;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_GET    = 3'd2,
        MODE_FIND   = 3'd3,
        MODE_CLEAR  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PACK
    } t_state;

    typedef struct packed {
        logic [2:0]       mode;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] element_value;
    } t_cmd;

    typedef struct packed {
        logic               ok;
        logic [VAL_W-1:0]   read_value;
        logic [FIDX_W-1:0]  found_index;
        logic [CNT_O_W-1:0] item_count;
        logic               full_res;
        logic               empty_res;
        logic [VAL_W-1:0]   first_value;
        logic [VAL_W-1:0]   last_value;
    } t_result;

    typedef struct packed {
        logic insert_en;
        logic remove_en;
        logic find_en;
    } t_cell_ctl;

endpackage

FILE: src/fixed_capacity_ordered_list_core.sv
// Fixed-capacity ordered list core: a row of DEPTH slot cells plus control.
// Each accepted beat runs an execute step (shift/compare in all cells), then an encode step
// (first match, last), then the result strobe; a new beat is taken only while not busy.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active low) empties the list and sets the capacity limit to 16;
// entry contents are not cleared and are never read above the count.
module fixed_capacity_ordered_list_core #(
    parameter int DEPTH      = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  folc_pkg::t_cmd           i_cmd,
    input  logic                     i_cfg_we,
    input  logic [folc_pkg::LIM_W-1:0] i_cfg_data,
    output logic                     o_valid,
    output folc_pkg::t_result        o_res
);
    import folc_pkg::*;

    // count must hold DEPTH itself; compares run at the wider of count and position
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(DEPTH);

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [LIM_W-1:0]   r_limit;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_op_ok, n_op_ok;
    logic [VAL_W-1:0]   r_rd, n_rd;
    logic               r_valid, n_valid;
    t_result            r_res, n_res;

    // ---------------------------------------------------------------
    // cell row wiring
    // ---------------------------------------------------------------
    t_cell_ctl              cell_ctl;
    logic [ELEM_WIDTH-1:0]  cell_val  [DEPTH];
    logic [ELEM_WIDTH-1:0]  cell_read [DEPTH];
    logic [ELEM_WIDTH-1:0]  cell_last [DEPTH];
    logic [DEPTH-1:0]       cell_match;
    logic [ELEM_WIDTH-1:0]  key;
    logic [63:0]            key_wide;

    logic [CMP_W-1:0] pos_x, cnt_x, lim_x, last_pos;
    logic             ins_ok, rd_ok, exec;

    assign busy = (r_state != ST_IDLE);
    assign exec = (r_state == ST_EXEC);

    // keep the value in ELEM_WIDTH bits
    assign key_wide = {32'b0, r_cmd.element_value};
    assign key      = key_wide[ELEM_WIDTH-1:0];

    assign pos_x    = CMP_W'(r_cmd.position);
    assign cnt_x    = CMP_W'(r_count);
    // a limit above the built depth clamps to the depth
    assign lim_x    = (CMP_W'(r_limit) > DEPTH_X) ? DEPTH_X : CMP_W'(r_limit);
    assign last_pos = cnt_x - CMP_W'(1);

    assign ins_ok = (pos_x <= cnt_x) && (cnt_x < lim_x) && (cnt_x < DEPTH_X);
    assign rd_ok  = (pos_x < cnt_x);

    always_comb begin
        cell_ctl.insert_en = exec && (r_cmd.mode == MODE_INSERT) && ins_ok;
        cell_ctl.remove_en = exec && (r_cmd.mode == MODE_REMOVE) && rd_ok;
        cell_ctl.find_en   = exec && (r_cmd.mode == MODE_FIND);
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [ELEM_WIDTH-1:0] left_val, right_val;
            if (g == 0) begin : g_first
                assign left_val = '0;
            end else begin : g_mid_l
                assign left_val = cell_val[g-1];
            end
            if (g == DEPTH - 1) begin : g_end
                assign right_val = '0;
            end else begin : g_mid_r
                assign right_val = cell_val[g+1];
            end

            folc_cell #(
                .IDX        (g),
                .ELEM_WIDTH (ELEM_WIDTH),
                .CMP_W      (CMP_W)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl),
                .i_pos      (pos_x),
                .i_cnt      (cnt_x),
                .i_last_pos (last_pos),
                .i_key      (key),
                .i_left     (left_val),
                .i_right    (right_val),
                .o_value    (cell_val[g]),
                .o_read     (cell_read[g]),
                .o_last     (cell_last[g]),
                .o_match    (cell_match[g])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // reductions over the row: at most one cell drives each bus
    // ---------------------------------------------------------------
    logic [ELEM_WIDTH-1:0] read_or, last_or;
    logic [IDX_W-1:0]      first_hit;
    logic [63:0]           read_wide, last_wide, first_wide;

    always_comb begin
        read_or   = '0;
        last_or   = '0;
        first_hit = '0;
        for (int i = 0; i < DEPTH; i++) begin
            read_or = read_or | cell_read[i];
            last_or = last_or | cell_last[i];
        end
        // lowest matching slot wins
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (cell_match[i]) begin
                first_hit = IDX_W'(i);
            end
        end
    end

    assign read_wide  = 64'(read_or);
    assign last_wide  = 64'(last_or);
    assign first_wide = 64'(cell_val[0]);

    // ---------------------------------------------------------------
    // sequencer: accept -> execute -> pack result
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_op_ok = r_op_ok;
        n_rd    = r_rd;
        n_valid = 1'b0;
        n_res   = r_res;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // cells shift or compare on this edge; settle count and read data
                n_op_ok = 1'b0;
                n_rd    = '0;
                case (r_cmd.mode)
                    MODE_INSERT: begin
                        if (ins_ok) begin
                            n_count = r_count + CNT_W'(1);
                            n_op_ok = 1'b1;
                        end
                    end
                    MODE_REMOVE: begin
                        if (rd_ok) begin
                            n_count = r_count - CNT_W'(1);
                            n_op_ok = 1'b1;
                            n_rd    = read_wide[VAL_W-1:0];
                        end
                    end
                    MODE_GET: begin
                        if (rd_ok) begin
                            n_op_ok = 1'b1;
                            n_rd    = read_wide[VAL_W-1:0];
                        end
                    end
                    MODE_CLEAR: begin
                        n_count = '0;
                        n_op_ok = 1'b1;
                    end
                    default: begin
                        // find settles in the pack step; unused modes do nothing
                    end
                endcase
                n_state = ST_PACK;
            end
            ST_PACK: begin
                n_valid           = 1'b1;
                n_res.ok          = (r_cmd.mode == MODE_FIND) ? (|cell_match) : r_op_ok;
                n_res.read_value  = r_rd;
                n_res.found_index = ((r_cmd.mode == MODE_FIND) && (|cell_match))
                                    ? FIDX_W'(first_hit) : '0;
                n_res.item_count  = CNT_O_W'(r_count);
                n_res.full_res    = (cnt_x >= lim_x);
                n_res.empty_res   = (r_count == '0);
                n_res.first_value = (r_count == '0) ? '0 : first_wide[VAL_W-1:0];
                n_res.last_value  = (r_count == '0) ? '0 : last_wide[VAL_W-1:0];
                n_state           = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_limit <= LIMIT_RESET;
            r_valid <= 1'b0;
            r_op_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_op_ok <= n_op_ok;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // payload: hold the command beat, the read data and the result
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
        r_rd  <= n_rd;
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: src/folc_cell.sv
// One slot of the ordered list: holds an entry, shifts with its neighbors.
// Depends on folc_pkg for the control struct.
module folc_cell #(
    parameter int IDX        = 0,
    parameter int ELEM_WIDTH = 32,
    parameter int CMP_W      = 5
) (
    input  logic                      i_clk,
    input  folc_pkg::t_cell_ctl       i_ctl,
    input  logic [CMP_W-1:0]          i_pos,
    input  logic [CMP_W-1:0]          i_cnt,
    input  logic [CMP_W-1:0]          i_last_pos,
    input  logic [ELEM_WIDTH-1:0]     i_key,
    input  logic [ELEM_WIDTH-1:0]     i_left,
    input  logic [ELEM_WIDTH-1:0]     i_right,
    output logic [ELEM_WIDTH-1:0]     o_value,
    output logic [ELEM_WIDTH-1:0]     o_read,
    output logic [ELEM_WIDTH-1:0]     o_last,
    output logic                      o_match
);
    import folc_pkg::*;

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [ELEM_WIDTH-1:0] r_value, n_value;
    logic                  r_match, n_match;

    always_comb begin
        n_value = r_value;
        if (i_ctl.insert_en) begin
            if (MY_IDX > i_pos) begin
                n_value = i_left;
            end else if (MY_IDX == i_pos) begin
                n_value = i_key;
            end
        end else if (i_ctl.remove_en) begin
            if (MY_IDX >= i_pos) begin
                n_value = i_right;
            end
        end
        // only slots below the count take part in a search
        n_match = i_ctl.find_en && (MY_IDX < i_cnt) && (r_value == i_key);
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= n_match;
    end

    assign o_value = r_value;
    assign o_match = r_match;
    assign o_read  = (MY_IDX == i_pos) ? r_value : '0;
    assign o_last  = (MY_IDX == i_last_pos) ? r_value : '0;

endmodule

FILE: src/folc_checker.sv
// Port-level checks for the ordered list core, bound to the top level.
// Depends on folc_pkg and fixed_capacity_ordered_list_core.
module folc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               o_valid,
    input  folc_pkg::t_result  o_res
);
    import folc_pkg::*;

    // an accepted beat always produces its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##2 o_valid)
        else $error("result strobe missing after accepted beat");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.empty_res == (o_res.item_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.empty_res) |->
            ((o_res.first_value == '0) && (o_res.last_value == '0)))
        else $error("first or last nonzero on empty list");

endmodule

bind fixed_capacity_ordered_list_core folc_checker u_folc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);
